### rtl/core/rpcf_pkg.sv
// rpcf_pkg.sv: shared types, byte-kind codes and the CRC-16 byte step of the packet framer
`default_nettype none
package rpcf_pkg;

   localparam int POS_W = 5;

   // Classification of a packet position
   localparam logic [2:0] KIND_PAYLOAD = 3'd0;
   localparam logic [2:0] KIND_ACK     = 3'd1;
   localparam logic [2:0] KIND_SENDER  = 3'd2;
   localparam logic [2:0] KIND_DEST    = 3'd3;
   localparam logic [2:0] KIND_LENGTH  = 3'd4;
   localparam logic [2:0] KIND_CRC_HI  = 3'd5;
   localparam logic [2:0] KIND_CRC_LO  = 3'd6;

   localparam logic DIR_OUT = 1'b0;
   localparam logic DIR_IN  = 1'b1;

   localparam logic [1:0] CSR_OWN_ADDRESS  = 2'd0;
   localparam logic [1:0] CSR_DEST_ADDRESS = 2'd1;
   localparam logic [1:0] CSR_ACK_REQUEST  = 2'd2;

   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_TOP  = 16'h8000;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
      logic [7:0] payload_length;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [4:0] byte_index;
      logic       last;
      logic       crc_match;
      logic       ack_wanted_here;
      logic [7:0] sender_address;
      logic [7:0] received_length;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] own_address;
      logic [7:0] dest_address;
      logic       ack_request;
   } cfg_type;

   // Classified word passed from front to back
   typedef struct packed {
      logic             dir;
      logic [POS_W-1:0] pos;
      logic             last;
      logic [2:0]       kind;
      logic [7:0]       data_byte;
      logic [7:0]       payload_length;
   } entry_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if ((c & CRC_TOP) != 16'h0000) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

### rtl/core/rpcf_front.sv
// rpcf_front.sv: tracks packet position and direction, classifies each accepted word
`default_nettype none
module rpcf_front #(
   parameter int PACKET_BYTES = 32
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   input  rpcf_pkg::req_payload_type req_payload,
   output logic                     push_valid,
   input  wire                      push_ready,
   output rpcf_pkg::entry_type      push_entry
);
   import rpcf_pkg::*;

   localparam logic [POS_W-1:0] POS_LAST   = POS_W'(PACKET_BYTES - 1);
   localparam logic [POS_W-1:0] POS_CRC_HI = POS_W'(PACKET_BYTES - 2);
   localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(PACKET_BYTES - 3);
   localparam logic [POS_W-1:0] POS_DEST   = POS_W'(PACKET_BYTES - 4);
   localparam logic [POS_W-1:0] POS_SENDER = POS_W'(PACKET_BYTES - 5);
   localparam logic [POS_W-1:0] POS_ACK    = POS_W'(PACKET_BYTES - 6);

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             dir_ff, dir_in;
   logic             restart;
   logic [POS_W-1:0] eff_pos;
   logic             eff_dir;
   logic             is_last;
   logic [2:0]       kind;
   logic             accept;

   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   // direction change mid-packet abandons it: this word becomes byte 0
   assign restart = (pos_ff != '0) && (req_payload.req_type != dir_ff);
   assign eff_pos = restart ? '0 : pos_ff;
   assign eff_dir = (eff_pos == '0) ? req_payload.req_type : dir_ff;
   assign is_last = (eff_pos == POS_LAST);

   always_comb begin
      priority if (eff_pos == POS_ACK)    kind = KIND_ACK;
      else if (eff_pos == POS_SENDER)     kind = KIND_SENDER;
      else if (eff_pos == POS_DEST)       kind = KIND_DEST;
      else if (eff_pos == POS_LENGTH)     kind = KIND_LENGTH;
      else if (eff_pos == POS_CRC_HI)     kind = KIND_CRC_HI;
      else if (eff_pos == POS_LAST)       kind = KIND_CRC_LO;
      else                                kind = KIND_PAYLOAD;
   end

   always_comb begin
      push_entry.dir            = eff_dir;
      push_entry.pos            = eff_pos;
      push_entry.last           = is_last;
      push_entry.kind           = kind;
      push_entry.data_byte      = req_payload.data_byte;
      push_entry.payload_length = req_payload.payload_length;
   end

   always_comb begin
      pos_in = pos_ff;
      dir_in = dir_ff;
      if (accept) begin
         pos_in = is_last ? '0 : eff_pos + POS_W'(1);
         dir_in = eff_dir;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         dir_ff <= DIR_OUT;
      end else begin
         pos_ff <= pos_in;
         dir_ff <= dir_in;
      end
   end

   a_pos_advance: assert property (@(posedge clock) disable iff (reset)
      accept && !is_last |=> pos_ff == $past(eff_pos) + POS_W'(1))
      else $error("position did not advance");
   a_pos_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && is_last |=> pos_ff == '0)
      else $error("position did not wrap after last byte");
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_LAST)
      else $error("position beyond packet");

endmodule
`default_nettype wire

### rtl/core/rpcf_queue.sv
// rpcf_queue.sv: two-entry queue of classified words between front and back
`default_nettype none
module rpcf_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_ready,
   input  rpcf_pkg::entry_type in_entry,
   output logic                out_valid,
   input  wire                 out_ready,
   output rpcf_pkg::entry_type out_entry
);
   import rpcf_pkg::*;

   entry_type   slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;
   logic        push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_entry = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == {1'b0, wr_ptr_ff ^ rd_ptr_ff} || count_ff == 2'd2)
      else $error("queue pointers disagree with count");
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue overfilled");
   a_full_ptrs: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("full queue with split pointers");

endmodule
`default_nettype wire

### rtl/core/rpcf_back.sv
// rpcf_back.sv: trailer substitution, CRC update, incoming checks and result register
`default_nettype none
module rpcf_back (
   input  wire                       clock,
   input  wire                       reset,
   input  rpcf_pkg::cfg_type         cfg,
   input  wire                       pop_valid,
   output logic                      pop_ready,
   input  rpcf_pkg::entry_type       pop_entry,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output rpcf_pkg::rsp_payload_type rsp_payload
);
   import rpcf_pkg::*;

   logic [15:0]     crc_ff, crc_in;
   logic [7:0]      rx_crc_hi_ff, rx_crc_hi_in;
   logic            ack_seen_ff, ack_seen_in;
   logic            addr_me_ff, addr_me_in;
   logic [7:0]      sender_ff, sender_in;
   logic [7:0]      length_ff, length_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff, out_in;

   logic            pop;
   logic [15:0]     crc_base;
   logic [7:0]      ob;
   logic            feeds_crc;
   logic            match;

   assign pop_ready   = !out_valid_ff || rsp_ready;
   assign pop         = pop_valid && pop_ready;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   // byte 0 starts a fresh CRC whatever the previous packet left
   assign crc_base  = (pop_entry.pos == '0) ? 16'h0000 : crc_ff;
   assign feeds_crc = (pop_entry.kind != KIND_CRC_HI) && (pop_entry.kind != KIND_CRC_LO);
   assign match     = ({rx_crc_hi_ff, pop_entry.data_byte} == crc_base);

   always_comb begin
      ob = pop_entry.data_byte;
      if (pop_entry.dir == DIR_OUT) begin
         unique case (pop_entry.kind)
            KIND_ACK:    ob = {7'd0, cfg.ack_request};
            KIND_SENDER: ob = cfg.own_address;
            KIND_DEST:   ob = cfg.dest_address;
            KIND_LENGTH: ob = pop_entry.payload_length;
            KIND_CRC_HI: ob = crc_base[15:8];
            KIND_CRC_LO: ob = crc_base[7:0];
            default:     ob = pop_entry.data_byte;
         endcase
      end
   end

   always_comb begin
      crc_in       = crc_ff;
      rx_crc_hi_in = rx_crc_hi_ff;
      ack_seen_in  = ack_seen_ff;
      addr_me_in   = addr_me_ff;
      sender_in    = sender_ff;
      length_in    = length_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (pop) begin
         crc_in = feeds_crc ? crc_feed(crc_base, ob) : crc_base;
         if (pop_entry.dir == DIR_IN) begin
            unique case (pop_entry.kind)
               KIND_ACK:    ack_seen_in  = (pop_entry.data_byte == 8'd1);
               KIND_SENDER: sender_in    = pop_entry.data_byte;
               KIND_DEST:   addr_me_in   = (pop_entry.data_byte == cfg.own_address);
               KIND_LENGTH: length_in    = pop_entry.data_byte;
               KIND_CRC_HI: rx_crc_hi_in = pop_entry.data_byte;
               default:     ;
            endcase
         end
         out_valid_in           = 1'b1;
         out_in.out_byte        = ob;
         out_in.byte_index      = pop_entry.pos;
         out_in.last            = pop_entry.last;
         out_in.crc_match       = 1'b0;
         out_in.ack_wanted_here = 1'b0;
         out_in.sender_address  = 8'd0;
         out_in.received_length = 8'd0;
         if (pop_entry.dir == DIR_IN && pop_entry.last) begin
            out_in.crc_match       = match;
            out_in.ack_wanted_here = match && ack_seen_ff && addr_me_ff;
            out_in.sender_address  = sender_ff;
            out_in.received_length = length_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      crc_ff       <= crc_in;
      rx_crc_hi_ff <= rx_crc_hi_in;
      ack_seen_ff  <= ack_seen_in;
      addr_me_ff   <= addr_me_in;
      sender_ff    <= sender_in;
      length_ff    <= length_in;
      out_ff       <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   a_status_on_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_ff.crc_match || out_ff.ack_wanted_here ||
                       out_ff.sender_address != 8'd0 || out_ff.received_length != 8'd0)
      |-> out_ff.last)
      else $error("incoming status outside last byte");
   a_ack_needs_crc: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.ack_wanted_here |-> out_ff.crc_match)
      else $error("ack wanted without CRC match");
   a_crc_lo_last: assert property (@(posedge clock) disable iff (reset)
      pop && pop_entry.kind == KIND_CRC_LO |-> pop_entry.last)
      else $error("CRC low byte not last");

endmodule
`default_nettype wire

### rtl/core/radio_packet_trailer_crc_framer_top.sv
// radio_packet_trailer_crc_framer_top.sv: top level of the packet trailer CRC framer
// A word accepted by the front is registered in a queue slot and then in the back result register.
// Throughput: one word per cycle while rsp_ready stays high; the front feeds a two-entry queue
// that stalls apart from the back result register, and the CRC byte step is combinational.
// Reset is synchronous, active high: position 0, outgoing direction, queue and result
// register empty, own_address 0, dest_address 1, ack_request 1.
`default_nettype none
module radio_packet_trailer_crc_framer_top #(
   parameter int PACKET_BYTES = 32
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  rpcf_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output rpcf_pkg::rsp_payload_type rsp_payload,
   input  wire                       csr_valid,
   output logic                      csr_ready,
   input  wire [1:0]                 csr_index,
   input  wire [7:0]                 csr_wdata
);
   import rpcf_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_OWN_ADDRESS:  cfg_in.own_address  = csr_wdata;
            CSR_DEST_ADDRESS: cfg_in.dest_address = csr_wdata;
            CSR_ACK_REQUEST:  cfg_in.ack_request  = csr_wdata[0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_address  <= 8'd0;
         cfg_ff.dest_address <= 8'd1;
         cfg_ff.ack_request  <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rpcf_front #(
      .PACKET_BYTES(PACKET_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   rpcf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (push_valid),
      .in_ready (push_ready),
      .in_entry (push_entry),
      .out_valid(pop_valid),
      .out_ready(pop_ready),
      .out_entry(pop_entry)
   );

   rpcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

endmodule
`default_nettype wire
